FILE: hw/rtl/pcm_float_sample_converter_assert.svh
// Assertion macros used by the checker file of the sample converter.
`ifndef PCM_FLOAT_SAMPLE_CONVERTER_ASSERT_SVH
`define PCM_FLOAT_SAMPLE_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define PFSC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define PFSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pfsc_pkg.sv
// Shared types and constants of the PCM / float sample converter.
package pfsc_pkg;

	// sample_format register
	localparam logic [3:0] FMT_LAST_INT = 4'd7;
	localparam logic [3:0] FMT_RESET    = 4'd8;

	// register index (paddr[2])
	localparam logic REG_SAMPLE_FORMAT = 1'b0;

	// action field
	localparam logic ACT_TO_FLOAT = 1'b0;
	localparam logic ACT_TO_INT   = 1'b1;

	// operation carried down the pipe
	localparam logic [1:0] OP_PASS = 2'd0;
	localparam logic [1:0] OP_I2F  = 2'd1;
	localparam logic [1:0] OP_F2I  = 2'd2;

	// sample width select (sample_format[2:1])
	localparam logic [1:0] W8  = 2'd0;
	localparam logic [1:0] W16 = 2'd1;
	localparam logic [1:0] W24 = 2'd2;
	localparam logic [1:0] W32 = 2'd3;

	// per-beat control traveling with the data
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] wsel;
		logic       uns;
		logic       sgn;
		logic       last;
	} ctl_t;

	// index of the sample's top bit: 7, 15, 23 or 31
	function automatic logic [7:0] top_bit(input logic [1:0] wsel);
		return {1'b0, wsel, 3'b000} + 8'd7;
	endfunction

endpackage

FILE: hw/rtl/pfsc_cfg_regs.sv
// APB register block holding the sample format.
module pfsc_cfg_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  sample_format
);

	logic [3:0] fmt_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr[2] == pfsc_pkg::REG_SAMPLE_FORMAT);

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pfsc_pkg::FMT_RESET;
		end else if (wr_en) begin
			fmt_q <= pwdata[3:0];
		end
	end

	// read mux; bits [1:0] of paddr are byte lanes
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == pfsc_pkg::REG_SAMPLE_FORMAT) begin
			prdata = {28'd0, fmt_q};
		end
	end

	assign sample_format = fmt_q;

endmodule

FILE: hw/rtl/pfsc_datapath.sv
// Four-stage conversion pipeline: operand prep, normalize, round, clamp/pack.
module pfsc_datapath (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [3:0]  sample_format,
	input  logic        action,
	input  logic [31:0] sample_word,
	input  logic        block_end,
	output logic        out_valid,
	output logic [31:0] out_word,
	output logic        out_last
);

	// ---------------- stage 1: decode, sign/magnitude, mantissa x scale
	pfsc_pkg::ctl_t ctl_d1, ctl_s1;
	logic        vld_s1;
	logic [46:0] dat_s1;
	logic [7:0]  exp_s1;
	logic        nan_s1;
	logic        flip;
	logic [31:0] sx;
	logic [31:0] mag_i;
	logic [7:0]  fe;
	logic [46:0] m47;
	logic [46:0] prod;
	logic [46:0] dat_d1;

	always_comb begin
		ctl_d1.wsel = sample_format[2:1];
		ctl_d1.uns  = sample_format[0];
		ctl_d1.last = block_end;
		if (sample_format > pfsc_pkg::FMT_LAST_INT) begin
			ctl_d1.op = pfsc_pkg::OP_PASS;
		end else if (action == pfsc_pkg::ACT_TO_INT) begin
			ctl_d1.op = pfsc_pkg::OP_F2I;
		end else begin
			ctl_d1.op = pfsc_pkg::OP_I2F;
		end

		// unsigned offset removal is a flip of the top sample bit
		flip = sample_format[0];
		unique case (ctl_d1.wsel)
			pfsc_pkg::W8:  sx = {{25{sample_word[7] ^ flip}}, sample_word[6:0]};
			pfsc_pkg::W16: sx = {{17{sample_word[15] ^ flip}}, sample_word[14:0]};
			pfsc_pkg::W24: sx = {{9{sample_word[23] ^ flip}}, sample_word[22:0]};
			default:       sx = {sample_word[31] ^ flip, sample_word[30:0]};
		endcase
		mag_i = sx[31] ? (32'd0 - sx) : sx;

		// float mantissa times full scale 2^k-1 (k = 7, 15, 23); 32-bit uses 2^31
		fe  = sample_word[30:23];
		m47 = {23'd0, (fe != 8'd0), sample_word[22:0]};
		unique case (ctl_d1.wsel)
			pfsc_pkg::W8:  prod = (m47 << 7) - m47;
			pfsc_pkg::W16: prod = (m47 << 15) - m47;
			pfsc_pkg::W24: prod = (m47 << 23) - m47;
			default:       prod = m47 << 23;
		endcase

		unique case (ctl_d1.op)
			pfsc_pkg::OP_F2I: begin
				dat_d1     = prod;
				ctl_d1.sgn = sample_word[31];
			end
			pfsc_pkg::OP_I2F: begin
				dat_d1     = {15'd0, mag_i};
				ctl_d1.sgn = sx[31];
			end
			default: begin
				dat_d1     = {15'd0, sample_word};
				ctl_d1.sgn = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_d1;
			dat_s1 <= dat_d1;
			exp_s1 <= fe;
			nan_s1 <= (fe == 8'hFF) && (sample_word[22:0] != 23'd0);
		end
	end

	// ---------------- stage 2: normalize, round product to single precision
	pfsc_pkg::ctl_t ctl_s2;
	logic        vld_s2;
	logic [31:0] dat_s2;
	logic [9:0]  fexp_s2;
	logic        nan_s2;
	logic        zero_s2;
	logic [4:0]  msb;
	logic [31:0] norm;
	logic [7:0]  iexp;
	logic [4:0]  shamt;
	logic [46:0] pn;
	logic        pinc;
	logic [24:0] psum;
	logic [23:0] pkeep;
	logic [9:0]  pexp;
	logic [31:0] dat_d2;
	logic [9:0]  fexp_d2;
	logic        zero_d2;

	always_comb begin
		// leading one of the integer magnitude
		msb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (dat_s1[i]) begin
				msb = 5'(i);
			end
		end
		norm = dat_s1[31:0] << (5'd31 - msb);
		iexp = {3'd0, msb} + 8'd127 - pfsc_pkg::top_bit(ctl_s1.wsel);

		// product lies one bit either side of a known place
		unique case (ctl_s1.wsel)
			pfsc_pkg::W8:  shamt = dat_s1[30] ? 5'd16 : 5'd17;
			pfsc_pkg::W16: shamt = dat_s1[38] ? 5'd8 : 5'd9;
			pfsc_pkg::W24: shamt = dat_s1[46] ? 5'd0 : 5'd1;
			default:       shamt = 5'd0;
		endcase
		pn    = dat_s1 << shamt;
		pinc  = pn[22] & ((|pn[21:0]) | pn[23]);
		psum  = {1'b0, pn[46:23]} + {24'd0, pinc};
		pkeep = psum[24] ? 24'h800000 : psum[23:0];
		pexp  = {2'd0, exp_s1} - 10'd127 - {5'd0, shamt} + {9'd0, psum[24]}
			+ ((ctl_s1.wsel == pfsc_pkg::W32) ? 10'd8 : 10'd0);

		unique case (ctl_s1.op)
			pfsc_pkg::OP_F2I: begin
				dat_d2  = {8'd0, pkeep};
				fexp_d2 = pexp;
				zero_d2 = (exp_s1 == 8'd0);
			end
			pfsc_pkg::OP_I2F: begin
				dat_d2  = norm;
				fexp_d2 = {2'd0, iexp};
				zero_d2 = (dat_s1[31:0] == 32'd0);
			end
			default: begin
				dat_d2  = dat_s1[31:0];
				fexp_d2 = 10'd0;
				zero_d2 = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2  <= ctl_s1;
			dat_s2  <= dat_d2;
			fexp_s2 <= fexp_d2;
			nan_s2  <= nan_s1;
			zero_s2 <= zero_d2;
		end
	end

	// ---------------- stage 3: round to 24 bits / to integer
	pfsc_pkg::ctl_t ctl_s3;
	logic        vld_s3;
	logic [31:0] dat_s3;
	logic        sat_s3;
	logic        iinc;
	logic [24:0] isum;
	logic [23:0] ikeep;
	logic [7:0]  iexp3;
	logic [31:0] fbits;
	logic signed [9:0] fsh;
	logic [9:0]  rsh;
	logic [49:0] ext;
	logic        rinc;
	logic [31:0] imag;
	logic        isat;
	logic [31:0] dat_d3;

	always_comb begin
		// integer to float: ties to even at bit 8
		iinc  = dat_s2[7] & ((|dat_s2[6:0]) | dat_s2[8]);
		isum  = {1'b0, dat_s2[31:8]} + {24'd0, iinc};
		ikeep = isum[24] ? 24'h800000 : isum[23:0];
		iexp3 = fexp_s2[7:0] + {7'd0, isum[24]};
		fbits = zero_s2 ? 32'd0 : {ctl_s2.sgn, iexp3, ikeep[22:0]};

		// float to integer: value = keep * 2^fsh
		fsh  = $signed(fexp_s2);
		rsh  = 10'd0 - fexp_s2;
		ext  = {dat_s2[23:0], 26'd0} >> rsh[4:0];
		rinc = ext[25] & ((|ext[24:0]) | ext[26]);
		imag = 32'd0;
		isat = 1'b0;
		if (nan_s2 || zero_s2) begin
			imag = 32'd0;
		end else if (fsh > 10'sd8) begin
			isat = 1'b1;
		end else if (fsh >= 10'sd0) begin
			imag = {8'd0, dat_s2[23:0]} << fexp_s2[3:0];
		end else if (rsh <= 10'd26) begin
			imag = {8'd0, ext[49:26]} + {31'd0, rinc};
		end

		unique case (ctl_s2.op)
			pfsc_pkg::OP_F2I: dat_d3 = imag;
			pfsc_pkg::OP_I2F: dat_d3 = fbits;
			default:          dat_d3 = dat_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3 <= ctl_s2;
			dat_s3 <= dat_d3;
			sat_s3 <= isat;
		end
	end

	// ---------------- stage 4: clamp, offset, output register
	logic        vld_s4;
	logic [31:0] dat_s4;
	logic        last_s4;
	logic [7:0]  topb;
	logic [31:0] half;
	logic [31:0] maxv;
	logic [31:0] mask;
	logic [31:0] sval;
	logic [31:0] dat_d4;

	always_comb begin
		topb = pfsc_pkg::top_bit(ctl_s3.wsel);
		half = 32'd1 << topb[4:0];
		maxv = half - 32'd1;
		mask = (ctl_s3.wsel == pfsc_pkg::W32) ? 32'hFFFF_FFFF : ((half << 1) - 32'd1);
		if (!ctl_s3.sgn) begin
			sval = (sat_s3 || dat_s3 > maxv) ? maxv : dat_s3;
		end else begin
			sval = 32'd0 - ((sat_s3 || dat_s3 > half) ? half : dat_s3);
		end
		if (ctl_s3.op == pfsc_pkg::OP_F2I) begin
			dat_d4 = (sval & mask) ^ (ctl_s3.uns ? half : 32'd0);
		end else begin
			dat_d4 = dat_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s4  <= dat_d4;
			last_s4 <= ctl_s3.last;
		end
	end

	assign out_valid = vld_s4;
	assign out_word  = dat_s4;
	assign out_last  = last_s4;

endmodule

FILE: hw/rtl/pcm_float_sample_converter.sv
// Top level of the PCM integer / IEEE single float sample converter.
// One sample beat enters per clock unless the output is stalled, and its
// result leaves through the four register stages of the datapath (operand
// prep, normalize, round, clamp and pack); a full pipe sustains one beat per
// cycle unless stalled. When the output beat is held by m_axis_tready low,
// all stages hold and s_axis_tready drops in the same cycle. sample_format
// selects s8, u8, s16, u16, s24, u24, s32, u32 or float passthrough (8 and
// above); write it only while no beat is in flight.
module pcm_float_sample_converter (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] sample_word
	input  logic [0:0]  s_axis_tuser,   // [0] action
	input  logic        s_axis_tlast,
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] converted_word
	output logic        m_axis_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0] sample_format;
	logic       en;

	// whole pipe advances unless the output beat is stalled
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	pfsc_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_format (sample_format)
	);

	pfsc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_axis_tvalid),
		.sample_format (sample_format),
		.action        (s_axis_tuser[0]),
		.sample_word   (s_axis_tdata),
		.block_end     (s_axis_tlast),
		.out_valid     (m_axis_tvalid),
		.out_word      (m_axis_tdata),
		.out_last      (m_axis_tlast)
	);

endmodule

FILE: hw/rtl/pfsc_checker.sv
// Port-level checker for the sample converter, bound to the top level.
`include "pcm_float_sample_converter_assert.svh"

module pfsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// a stalled output beat stays put
	`PFSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

	// input side is open exactly when the output side can move
	`PFSC_ASSERT_IMPLY(a_ready_link, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

	// a format write reads back on the next cycle
	`PFSC_ASSERT_NEXT(a_fmt_readback, psel && penable && pwrite && !paddr[2], paddr[2] || prdata[3:0] == $past(pwdata[3:0]), "format register readback mismatch")

endmodule

bind pcm_float_sample_converter pfsc_checker u_pfsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata)
);
